/* hdl/assert_macros.svh */
// assertion macros shared by the substring search rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ss assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ss assertion failed");

`endif

/* hdl/ss_pkg.sv */
// shared types and constants for the substring search block
// no dependencies
package ss_pkg;

    // default sizes
    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam int LEN_REG_W = 5;

    // register indexes, one per 8-byte slot
    localparam logic [1:0] REG_PAT_LO  = 2'd0;
    localparam logic [1:0] REG_PAT_HI  = 2'd1;
    localparam logic [1:0] REG_PAT_LEN = 2'd2;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    // result item
    typedef struct packed {
        logic        found;
        logic [15:0] match_start;
        logic        overrun;
    } t_out;

    // configuration register contents
    typedef struct packed {
        logic [DATA_W-1:0]    pat_hi;
        logic [DATA_W-1:0]    pat_lo;
        logic [LEN_REG_W-1:0] pat_len;
    } t_cfg;

    // control handed to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

/* hdl/ss_cfg_regs.sv */
// apb register file holding the search pattern and its length
// depends on ss_pkg
module ss_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ss_pkg::ADDR_W-1:0]  paddr,
    input  logic [ss_pkg::DATA_W-1:0]  pwdata,
    output logic [ss_pkg::DATA_W-1:0]  prdata,
    output logic                       pready,
    output ss_pkg::t_cfg               o_cfg
);
    import ss_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_lo  <= '0;
            r_cfg.pat_hi  <= '0;
            r_cfg.pat_len <= LEN_REG_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_PAT_LO:  r_cfg.pat_lo  <= pwdata;
                REG_PAT_HI:  r_cfg.pat_hi  <= pwdata;
                REG_PAT_LEN: r_cfg.pat_len <= pwdata[LEN_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_PAT_LO:  prdata = r_cfg.pat_lo;
            REG_PAT_HI:  prdata = r_cfg.pat_hi;
            REG_PAT_LEN: prdata = DATA_W'(r_cfg.pat_len);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/ss_cell.sv */
// one window cell: holds a text byte, passes it on, compares the incoming byte
// depends on ss_pkg
module ss_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ss_pkg::t_cell_ctl i_ctl,
    input  ss_pkg::t_cfg      i_cfg,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [7:0]        i_prev,
    output logic [7:0]        o_byte,
    output logic              o_hit
);
    import ss_pkg::*;

    logic [7:0]   r_byte;
    logic [4:0]   pat_k;
    logic [127:0] pat_all;
    logic [7:0]   exp_byte;
    logic         active;

    // shift register stage, cleared at end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.clear) begin
            r_byte <= '0;
        end else if (i_ctl.shift) begin
            r_byte <= i_prev;
        end
    end

    // this slot holds pattern byte len-1-idx once the new byte is in
    always_comb begin
        pat_all  = {i_cfg.pat_hi, i_cfg.pat_lo};
        pat_k    = 5'(i_len) - 5'(IDX) - 5'd1;
        exp_byte = pat_all[{pat_k[3:0], 3'b000} +: 8];
        active   = 5'(i_len) > 5'(IDX);
        o_hit    = !active || (i_prev == exp_byte);
    end

    assign o_byte = r_byte;

endmodule

/* hdl/substring_search_top.sv */
// Latency: a result is presented the cycle after its last byte's transfer, output free.
// Throughput: one byte per cycle unless stalled; every cell compares in the same cycle.
// A waiting result leaves the input open; a second one parks and holds the input off.
// Reset (synchronous, active low) clears the window, counters, flags and
// sets the pattern to all zero with length one.
// top: cell chain, position counter, match tracking; needs ss_pkg, ss_cell, ss_cfg_regs
module substring_search_top #(
    parameter int PATTERN_MAX   = ss_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = ss_pkg::POSITION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ss_pkg::t_in                i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ss_pkg::t_out               o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ss_pkg::ADDR_W-1:0]  paddr,
    input  logic [ss_pkg::DATA_W-1:0]  pwdata,
    output logic [ss_pkg::DATA_W-1:0]  prdata,
    output logic                       pready
);
    import ss_pkg::*;
    `include "assert_macros.svh"

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int PW    = POSITION_BITS + 1;
    localparam int SW    = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam logic [PW-1:0] LIMIT = {1'b1, {POSITION_BITS{1'b0}}};

    t_cfg                     cfg;
    t_cell_ctl                cell_ctl;
    logic [LEN_W-1:0]         eff_len;
    logic [7:0]               win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   hits;
    logic                     in_fire;
    logic                     out_take;

    logic [PW-1:0]            r_pos, n_pos;
    logic                     r_seen, n_seen;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic                     r_ovr, n_ovr;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;
    logic                     r_skid_valid, n_skid_valid;
    t_out                     r_skid, n_skid;
    t_out                     res;

    logic [PW-1:0]            count;
    logic [PW-1:0]            diff;
    logic [SW-1:0]            start_ext;

    // configuration registers
    ss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // clamp the programmed length to 1..PATTERN_MAX
    always_comb begin
        if (cfg.pat_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (cfg.pat_len > LEN_REG_W'(PATTERN_MAX)) begin
            eff_len = LEN_W'(PATTERN_MAX);
        end else begin
            eff_len = LEN_W'(cfg.pat_len);
        end
    end

    assign in_fire        = i_in_valid && o_in_ready;
    assign o_in_ready     = !r_skid_valid;
    assign out_take       = r_out_valid && i_out_ready;
    assign cell_ctl.shift = in_fire;
    assign cell_ctl.clear = in_fire && i_in_data.end_of_text;

    // row of window cells, newest byte enters cell 0
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [7:0] prev;
        if (j == 0) begin : g_head
            assign prev = i_in_data.text_byte;
        end else begin : g_body
            assign prev = win[j-1];
        end
        ss_cell #(
            .IDX   (j),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_cfg   (cfg),
            .i_len   (eff_len),
            .i_prev  (prev),
            .o_byte  (win[j]),
            .o_hit   (hits[j])
        );
    end

    // position counter, first-match tracking and result buffer
    always_comb begin
        n_pos        = r_pos;
        n_seen       = r_seen;
        n_start      = r_start;
        n_ovr        = r_ovr;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        res          = '0;
        count        = r_pos + PW'(1);
        diff         = count - PW'(eff_len);
        start_ext    = '0;
        // output transfer, spare result moves up
        if (out_take) begin
            n_out_valid  = r_skid_valid;
            n_skid_valid = 1'b0;
            if (r_skid_valid) begin
                n_out = r_skid;
            end
        end
        if (in_fire) begin
            if (r_pos[POSITION_BITS]) begin
                n_ovr = 1'b1;
            end else begin
                if ((count >= PW'(eff_len)) && !r_seen && (&hits)) begin
                    n_seen  = 1'b1;
                    n_start = diff[POSITION_BITS-1:0];
                end
                n_pos = count;
            end
            if (i_in_data.end_of_text) begin
                start_ext       = n_seen ? SW'(n_start) : '0;
                res.found       = n_seen;
                res.match_start = start_ext[15:0];
                res.overrun     = n_ovr;
                // output register first, spare register behind it
                if (n_out_valid) begin
                    n_skid       = res;
                    n_skid_valid = 1'b1;
                end else begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                end
                n_pos   = '0;
                n_seen  = 1'b0;
                n_start = '0;
                n_ovr   = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_seen       <= 1'b0;
            r_start      <= '0;
            r_ovr        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_seen       <= n_seen;
            r_start      <= n_start;
            r_ovr        <= n_ovr;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `SS_ASSERT_NEXT(a_last_gives_result, in_fire && i_in_data.end_of_text, r_out_valid)
    `SS_ASSERT_IMPL(a_pos_in_range, 1'b1, r_pos <= LIMIT)
    `SS_ASSERT_NEXT(a_match_sticky, r_seen && !(in_fire && i_in_data.end_of_text), r_seen)
    `SS_ASSERT_IMPL(a_no_start_without_match, o_out_valid && !o_out_data.found,
                    o_out_data.match_start == 16'd0)
    `SS_ASSERT_IMPL(a_spare_behind_out, r_skid_valid, r_out_valid)

endmodule

/* verif/substring_search_checker.sv */
// checker for the substring search block: watches the input, result and register ports
// keeps its own scan state and compares every result transfer; needs ss_pkg
module substring_search_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  ss_pkg::t_in               i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  ss_pkg::t_out              i_out_data,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [ss_pkg::ADDR_W-1:0] i_paddr,
    input  logic [ss_pkg::DATA_W-1:0] i_pwdata,
    input  logic                      i_pready,
    output int                        o_mismatches,
    output int                        o_pending
);
    import ss_pkg::*;

    localparam int unsigned WINDOW_DEPTH = 16;
    localparam logic [POSITION_BITS_DEF:0] POSITION_LIMIT = {1'b1, {POSITION_BITS_DEF{1'b0}}};

    // register copies
    logic [DATA_W-1:0]    pat_lo;
    logic [DATA_W-1:0]    pat_hi;
    logic [LEN_REG_W-1:0] pat_len;

    // per-text scan state
    logic [7:0]               window [WINDOW_DEPTH];
    logic [POSITION_BITS_DEF:0] position;
    logic                     seen;
    logic [15:0]              first_start;
    logic                     overrun_flag;

    t_out expected_reports [$];
    int   error_count;

    // zero-length codes act as one, long codes as the full window
    function automatic int unsigned used_length();
        int unsigned n;
        n = pat_len;
        if (n < 1) n = 1;
        if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
        return n;
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned k);
        logic [127:0] all_bytes;
        all_bytes = {pat_hi, pat_lo};
        return all_bytes[8*k +: 8];
    endfunction

    task automatic clear_text();
        foreach (window[i]) window[i] = '0;
        position     = '0;
        seen         = 1'b0;
        first_start  = '0;
        overrun_flag = 1'b0;
    endtask

    // shift one text byte in, look for the first full match, report on the last byte
    task automatic scan_byte(input t_in item);
        int unsigned len;
        int unsigned count;
        logic        hit;
        t_out        report;
        len = used_length();
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = item.text_byte;
        if (position >= POSITION_LIMIT) begin
            overrun_flag = 1'b1;
        end else begin
            count = position + 1;
            if (count >= len && !seen) begin
                hit = 1'b1;
                // pattern byte k sits len-1-k slots back
                for (int k = 0; k < len; k++) begin
                    if (window[len-1-k] != pattern_byte(k)) hit = 1'b0;
                end
                if (hit) begin
                    seen        = 1'b1;
                    first_start = 16'(count - len);
                end
            end
            position = count[POSITION_BITS_DEF:0];
        end
        if (item.end_of_text) begin
            report.found       = seen;
            report.match_start = seen ? first_start : 16'd0;
            report.overrun     = overrun_flag;
            expected_reports.push_back(report);
            clear_text();
        end
    endtask

    // sample every port at the rising edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pat_lo  = '0;
            pat_hi  = '0;
            pat_len = LEN_REG_W'(1);
            clear_text();
            expected_reports.delete();
            error_count = 0;
        end else begin
            // register write transfer
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:3])
                    REG_PAT_LO:  pat_lo  = i_pwdata;
                    REG_PAT_HI:  pat_hi  = i_pwdata;
                    REG_PAT_LEN: pat_len = i_pwdata[LEN_REG_W-1:0];
                    default: ;
                endcase
            end
            // text byte transfer
            if (i_in_valid && i_in_ready) scan_byte(i_in_data);
            // result transfer against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transfer with nothing expected: found %0d start %0d",
                           i_out_data.found, i_out_data.match_start);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_out_data.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_out_data.found);
                        error_count++;
                    end
                    if (i_out_data.match_start !== want.match_start) begin
                        $error("match_start: expected %0d, actual %0d",
                               want.match_start, i_out_data.match_start);
                        error_count++;
                    end
                    if (i_out_data.overrun !== want.overrun) begin
                        $error("overrun: expected %0d, actual %0d",
                               want.overrun, i_out_data.overrun);
                        error_count++;
                    end
                end
            end
        end
        o_pending    <= expected_reports.size();
        o_mismatches <= error_count;
    end

endmodule

/* verif/testbench.sv */
// top of the substring search test: clock, reset, text and register stimulus, verdict
// needs ss_pkg, substring_search_top and substring_search_checker
module testbench;
    import ss_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned CALM_ITEMS   = 1500;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned TEXT_LIMIT   = 1 << POSITION_BITS_DEF;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in               in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out              out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int          mismatches;
    int          pending;
    bit          idling    = 1'b1;
    bit          hold_req  = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;

    // stimulus-side view of the pattern
    logic [7:0]  pat_bytes [16];
    int unsigned pat_used;
    logic [7:0]  text_buf [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    substring_search_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    substring_search_checker scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    // run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        @(posedge clk);
        forever begin
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                out_ready <= 1'b0;
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // one register write: setup phase, access phase until pready, then idle
    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // one text byte transfer, with an optional idle burst in front
    task automatic send_byte(input logic [7:0] value, input logic last);
        if (idling && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_data.text_byte     <= value;
        in_data.end_of_text   <= last;
        do @(posedge clk); while (!(in_valid && in_ready));
        items_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    // stop offering and let every expected result come out
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the pattern bytes and a length code while the block is idle
    task automatic load_pattern(input logic [LEN_REG_W-1:0] len_code);
        logic [127:0] packed_bytes;
        wait_quiet();
        foreach (pat_bytes[k]) packed_bytes[8*k +: 8] = pat_bytes[k];
        apb_write(REG_PAT_LO, packed_bytes[63:0]);
        apb_write(REG_PAT_HI, packed_bytes[127:64]);
        apb_write(REG_PAT_LEN, DATA_W'(len_code));
        pat_used = (len_code == 0) ? 1 : (len_code > 16) ? 16 : len_code;
    endtask

    // a long run of zero bytes ending in the pattern, no idling
    task automatic send_long_text(input int unsigned total);
        for (int unsigned i = 0; i < total; i++) begin
            send_byte((i >= total - pat_used) ? pat_bytes[pat_used - (total - i)] : 8'h00,
                      i == total - 1);
        end
    endtask

    function automatic logic [7:0] alphabet_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h61;
            default: return 8'h62;
        endcase
    endfunction

    // random text leaning on pattern bytes, with whole or broken plants
    task automatic build_text();
        int unsigned len;
        int unsigned at;
        int unsigned plant_len;
        text_buf.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80)
                                          : $urandom_range(1, 2 * pat_used + 6);
        for (int unsigned i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
                0, 1:    text_buf.push_back(pat_bytes[$urandom_range(0, pat_used - 1)]);
                2:       text_buf.push_back(alphabet_byte());
                default: text_buf.push_back(8'($urandom));
            endcase
        end
        repeat ($urandom_range(0, 2)) begin
            plant_len = ($urandom_range(0, 4) == 0 && pat_used > 1) ? pat_used - 1 : pat_used;
            if (len >= plant_len && $urandom_range(0, 4) != 0) begin
                at = $urandom_range(0, len - plant_len);
                for (int unsigned k = 0; k < plant_len; k++) text_buf[at + k] = pat_bytes[k];
            end
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_end;
        logic [LEN_REG_W-1:0] len_code;
        bit small_set;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pattern is one zero byte: zeros are matched like any byte
        pat_used = 1;
        text_buf = '{8'h55, 8'h00, 8'hFF};
        send_text();

        // three-byte pattern: short text, then first of two matches
        foreach (pat_bytes[k]) pat_bytes[k] = 8'hFF;
        pat_bytes[0] = 8'h61;
        pat_bytes[1] = 8'h62;
        pat_bytes[2] = 8'h63;
        load_pattern(LEN_REG_W'(3));
        text_buf = '{8'h61, 8'h62};
        send_text();
        text_buf = '{8'h78, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63};
        send_text();

        // length code zero acts as one
        load_pattern(LEN_REG_W'(0));
        text_buf = '{8'h61};
        send_text();

        // length code 31 acts as sixteen, all-ones pattern
        foreach (pat_bytes[k]) pat_bytes[k] = 8'hFF;
        load_pattern(LEN_REG_W'(31));
        text_buf.delete();
        repeat (16) text_buf.push_back(8'hFF);
        send_text();

        // position counter edge: last checked byte, then saturation
        idling = 1'b0;
        pat_bytes[0] = 8'h57;
        pat_bytes[1] = 8'h58;
        pat_bytes[2] = 8'h59;
        pat_bytes[3] = 8'h5A;
        load_pattern(LEN_REG_W'(4));
        send_long_text(TEXT_LIMIT);
        send_long_text(TEXT_LIMIT + 2);
        load_pattern(LEN_REG_W'(1));
        send_long_text(TEXT_LIMIT);
        send_long_text(TEXT_LIMIT + 1);
        idling = 1'b1;

        // receiver holds off while short texts keep coming
        load_pattern(LEN_REG_W'(2));
        hold_req = 1'b1;
        repeat (30) begin
            build_text();
            while (text_buf.size() > 3) void'(text_buf.pop_back());
            send_text();
        end

        // random phases, each with its own pattern
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (phase % 8)
                0:       len_code = LEN_REG_W'(1);
                1:       len_code = LEN_REG_W'(16);
                2:       len_code = LEN_REG_W'(0);
                3:       len_code = LEN_REG_W'(31);
                4:       len_code = LEN_REG_W'($urandom_range(17, 30));
                5:       len_code = LEN_REG_W'($urandom_range(7, 15));
                default: len_code = LEN_REG_W'($urandom_range(1, 6));
            endcase
            small_set = $urandom_range(0, 1);
            foreach (pat_bytes[k]) pat_bytes[k] = small_set ? alphabet_byte() : 8'($urandom);
            load_pattern(len_code);
            phase_end = items_sent + $urandom_range(100, 200);
            while (items_sent < phase_end && items_sent < RANDOM_ITEMS) begin
                idling = (items_sent < CALM_ITEMS);
                build_text();
                send_text();
            end
            phase++;
        end

        // drain and report
        wait_quiet();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* substring_search_top.f */
+incdir+hdl
hdl/ss_pkg.sv
hdl/ss_cfg_regs.sv
hdl/ss_cell.sv
hdl/substring_search_top.sv
verif/substring_search_checker.sv
verif/testbench.sv
